// File: rtl/mwps_pkg.sv
`default_nettype none

package mwps_pkg;

   // Default counter width; the block works for widths of 8 to 32 bits.
   localparam int COUNTER_WIDTH = 16;

   localparam int NUM_CFG   = 8;
   localparam int CFG_WIDTH = 16;
   localparam int IDX_WIDTH = 3;
   localparam int PH_WIDTH  = 3;

   // Phase codes.
   localparam logic [PH_WIDTH-1:0] PH_SLEEP    = 3'd0;
   localparam logic [PH_WIDTH-1:0] PH_DEBOUNCE = 3'd1;
   localparam logic [PH_WIDTH-1:0] PH_BOOT     = 3'd2;
   localparam logic [PH_WIDTH-1:0] PH_WAIT     = 3'd3;
   localparam logic [PH_WIDTH-1:0] PH_CLEAR    = 3'd4;
   localparam logic [PH_WIDTH-1:0] PH_DEAD     = 3'd5;

   // Configuration register indexes.
   localparam logic [IDX_WIDTH-1:0] CFG_DEBOUNCE    = 3'd0;
   localparam logic [IDX_WIDTH-1:0] CFG_BOOT        = 3'd1;
   localparam logic [IDX_WIDTH-1:0] CFG_BOOT_BLINK  = 3'd2;
   localparam logic [IDX_WIDTH-1:0] CFG_TIMEOUT     = 3'd3;
   localparam logic [IDX_WIDTH-1:0] CFG_WAIT_BLINK  = 3'd4;
   localparam logic [IDX_WIDTH-1:0] CFG_MOTION_POLL = 3'd5;
   localparam logic [IDX_WIDTH-1:0] CFG_DEAD        = 3'd6;
   localparam logic [IDX_WIDTH-1:0] CFG_DEAD_BLINK  = 3'd7;

   // Register values after reset, in index order.
   localparam logic [CFG_WIDTH-1:0] CFG_RESET [NUM_CFG] = '{
      16'd1, 16'd60, 16'd2, 16'd3600, 16'd10, 16'd10, 16'd6000, 16'd20
   };

   typedef struct packed {
      logic motion;
      logic job_done;
   } req_type;

   typedef struct packed {
      logic                power_enable;
      logic                wake_signal;
      logic                led;
      logic [PH_WIDTH-1:0] phase;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/motion_wake_power_sequencer.sv
`default_nettype none
// Each result is registered into the head, or into the skid entry while the head is full.
// Throughput: one tick per cycle while req_stall is low; the phase and counter update is one
// short step between the state registers and a two-entry result buffer.
// Reset (synchronous, active high): phase to sleep, counters, LED and motion latch
// to zero, configuration registers to their defaults, result buffer emptied.

module motion_wake_power_sequencer
   import mwps_pkg::*;
#(
   parameter int COUNTER_WIDTH = mwps_pkg::COUNTER_WIDTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [IDX_WIDTH-1:0] csr_index,
   input  wire logic [CFG_WIDTH-1:0] csr_data
);

   localparam int CW = COUNTER_WIDTH;
   localparam int LW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;
   localparam logic [LW-1:0] CNT_MAX_L = LW'((64'd1 << CW) - 64'd1);
   localparam logic [CW-1:0] CNT_MAX   = {CW{1'b1}};
   localparam logic [CW-1:0] CNT_ONE   = CW'(1);

   // Saturating increment.
   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
      logic [CW-1:0] r;
      r = (c == CNT_MAX) ? c : c + CNT_ONE;
      return r;
   endfunction

   // Blink period: clamped to the counter range, zero kept as zero.
   function automatic logic [CW-1:0] period_of(input logic [CFG_WIDTH-1:0] v);
      logic [LW-1:0] w;
      w = LW'(v);
      if (w > CNT_MAX_L) begin
         w = CNT_MAX_L;
      end
      return w[CW-1:0];
   endfunction

   // Phase length: zero acts as one, clamped to the counter range.
   function automatic logic [CW-1:0] limit_of(input logic [CFG_WIDTH-1:0] v);
      logic [CW-1:0] r;
      r = period_of(v);
      if (r == '0) begin
         r = CNT_ONE;
      end
      return r;
   endfunction

   // Configuration registers.
   logic [CFG_WIDTH-1:0] cfg_ff [NUM_CFG];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CFG; i++) begin
            cfg_ff[i] <= CFG_RESET[i];
         end
      end else if (csr_valid && csr_ready) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   // Sequencer state.
   logic [PH_WIDTH-1:0] phase_ff, phase_in;
   logic [CW-1:0]       pcount_ff, pcount_in;
   logic [CW-1:0]       bcount_ff, bcount_in;
   logic                led_ff, led_in;
   logic                latch_ff, latch_in;

   // Result buffer: head register and a skid entry behind it.
   rsp_type head_ff, skid_ff, result;
   logic    head_valid_ff, skid_valid_ff;
   logic    push, pop;

   assign req_stall = skid_valid_ff;
   assign push      = req_valid && !req_stall;
   assign rsp_valid = head_valid_ff;
   assign rsp_data  = head_ff;
   assign pop       = head_valid_ff && !rsp_stall;

   // Next state for one tick.
   always_comb begin
      logic [CW-1:0] inc;
      logic [CW-1:0] binc;
      logic [CW-1:0] bper;
      logic          enter;
      logic [PH_WIDTH-1:0] enter_phase;
      logic          enter_led;
      logic          relatch;

      phase_in    = phase_ff;
      pcount_in   = pcount_ff;
      bcount_in   = bcount_ff;
      led_in      = led_ff;
      latch_in    = latch_ff;
      inc         = sat_inc(pcount_ff);
      binc        = sat_inc(bcount_ff);
      bper        = '0;
      enter       = 1'b0;
      enter_phase = PH_SLEEP;
      enter_led   = 1'b0;
      relatch     = 1'b0;

      // Blink period of the current phase.
      case (phase_ff)
         PH_BOOT: begin
            bper = period_of(cfg_ff[CFG_BOOT_BLINK]);
         end
         PH_WAIT: begin
            bper = period_of(cfg_ff[CFG_WAIT_BLINK]);
         end
         PH_DEAD: begin
            bper = period_of(cfg_ff[CFG_DEAD_BLINK]);
         end
         default: begin
            bper = '0;
         end
      endcase

      case (phase_ff)
         PH_SLEEP: begin
            if (req_data.motion != latch_ff) begin
               enter       = 1'b1;
               enter_phase = PH_DEBOUNCE;
            end
         end
         PH_DEBOUNCE: begin
            pcount_in = inc;
            if (inc >= limit_of(cfg_ff[CFG_DEBOUNCE])) begin
               enter = 1'b1;
               if (req_data.motion) begin
                  enter_phase = PH_BOOT;
                  enter_led   = 1'b1;
               end else begin
                  enter_phase = PH_SLEEP;
                  relatch     = 1'b1;
               end
            end
         end
         PH_BOOT, PH_WAIT, PH_DEAD: begin
            pcount_in = inc;
            bcount_in = binc;
            if (binc >= bper) begin
               led_in    = !led_ff;
               bcount_in = '0;
            end
            if (phase_ff == PH_BOOT) begin
               if (inc >= limit_of(cfg_ff[CFG_BOOT])) begin
                  enter       = 1'b1;
                  enter_phase = PH_WAIT;
               end
            end else if (phase_ff == PH_WAIT) begin
               if (req_data.job_done || inc >= limit_of(cfg_ff[CFG_TIMEOUT])) begin
                  enter       = 1'b1;
                  enter_phase = PH_CLEAR;
               end
            end else begin
               if (inc >= limit_of(cfg_ff[CFG_DEAD])) begin
                  enter       = 1'b1;
                  enter_phase = PH_SLEEP;
                  relatch     = 1'b1;
               end
            end
         end
         PH_CLEAR: begin
            // Motion is sampled on the first tick and then once per poll period.
            pcount_in = inc;
            if ((inc >= limit_of(cfg_ff[CFG_MOTION_POLL]) || inc == CNT_ONE)
                  && !req_data.motion) begin
               enter       = 1'b1;
               enter_phase = PH_DEAD;
            end else if (inc >= limit_of(cfg_ff[CFG_MOTION_POLL])) begin
               pcount_in = CNT_ONE;
            end
         end
         default: begin
            // An unused phase code falls back to sleep.
            enter       = 1'b1;
            enter_phase = PH_SLEEP;
            relatch     = 1'b1;
         end
      endcase

      if (enter) begin
         phase_in  = enter_phase;
         pcount_in = '0;
         bcount_in = '0;
         led_in    = enter_led;
      end
      if (relatch) begin
         latch_in = req_data.motion;
      end
   end

   // Result as seen after the tick.
   always_comb begin
      logic on;
      on = (phase_in == PH_BOOT) || (phase_in == PH_WAIT);
      result.power_enable = on;
      result.wake_signal  = on;
      result.led          = (on || phase_in == PH_DEAD) ? led_in : 1'b0;
      result.phase        = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SLEEP;
         pcount_ff <= '0;
         bcount_ff <= '0;
         led_ff    <= 1'b0;
         latch_ff  <= 1'b0;
      end else if (push) begin
         phase_ff  <= phase_in;
         pcount_ff <= pcount_in;
         bcount_ff <= bcount_in;
         led_ff    <= led_in;
         latch_ff  <= latch_in;
      end
   end

   // Result buffer control; a transfer in never meets a full skid entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else if (!push) begin
            head_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            head_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            head_ff <= skid_ff;
         end else if (push) begin
            head_ff <= result;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            skid_ff <= result;
         end else begin
            head_ff <= result;
         end
      end
   end

   // The skid entry is only ever occupied behind a full head.
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry valid while head is empty");

   // Draining the skid entry leaves the head full.
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && skid_valid_ff) |=> head_valid_ff)
      else $error("head lost when skid entry drained");

   // Sleep is only ever left towards debounce.
   a_sleep_exit: assert property (@(posedge clock) disable iff (reset)
      (push && phase_ff == PH_SLEEP) |=> (phase_ff == PH_SLEEP || phase_ff == PH_DEBOUNCE))
      else $error("sleep left to a phase other than debounce");

endmodule

`default_nettype wire
